// ===== rtl/mqlf_pkg.sv =====
// Package with the shared types and codes of the multi-queue linked FIFO.
`timescale 1ns / 1ps
`default_nettype none

package mqlf_pkg;

  localparam logic KIND_ENQ   = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    RES_ENTRY  = 2'd0,
    RES_EMPTY  = 2'd1,
    RES_FULL   = 2'd2,
    RES_BADDAY = 2'd3
  } mqlf_res_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ENQ_FIN,
    ST_SINGLE,
    ST_DRAIN
  } mqlf_state_e;

  typedef struct packed {
    logic      init_wr;
    logic      accept;
    mqlf_res_e code;
    logic      enq_start;
    logic      enq_fin;
    logic      drain_start;
    logic      drain_emit;
    logic      single_load;
  } mqlf_cmd_t;

  typedef struct packed {
    logic kind;
    logic day_bad;
    logic pool_full;
    logic queue_empty;
    logic slot_free;
    logic init_last;
    logic walk_final;
  } mqlf_status_t;

endpackage

`default_nettype wire

// ===== rtl/multi_queue_linked_fifo.sv =====
// Top level of the multi-queue linked FIFO: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// NUM_QUEUES queues share a pool of POOL_DEPTH linked entries with a free list.
// After reset the block stalls its input while it writes the initial free-list
// links into the link memory, one entry per cycle.
// One transaction is in work at a time. An enqueue reads the free-list link
// memory, then updates the free head. A bad day, a full pool or an empty queue
// gives one result, loaded into the output register once the output is free.
// A drain of N entries emits them in order: the walk follows the link memory
// one entry per cycle through its registered read port, and holds whenever
// the output register is stalled. A drain emits at most POOL_DEPTH entries.

module multi_queue_linked_fifo #(
  parameter int NUM_QUEUES = 7,
  parameter int POOL_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [2:0]  day_i,
  input  wire logic [15:0] film_id_i,
  input  wire logic [15:0] client_id_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [15:0]      out_film_o,
  output logic [15:0]      out_client_o,
  output logic             last_o
);

  mqlf_pkg::mqlf_cmd_t    cmd;
  mqlf_pkg::mqlf_status_t sts;

  mqlf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mqlf_datapath #(
    .NUM_QUEUES (NUM_QUEUES),
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (kind_i),
    .day_i        (day_i),
    .film_id_i    (film_id_i),
    .client_id_i  (client_id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .out_film_o   (out_film_o),
    .out_client_o (out_client_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/mqlf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mqlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mqlf_ctrl.sv =====
// Controller state machine of the multi-queue linked FIFO.
`timescale 1ns / 1ps
`default_nettype none

module mqlf_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire mqlf_pkg::mqlf_status_t sts_i,
  output mqlf_pkg::mqlf_cmd_t        cmd_o
);

  mqlf_pkg::mqlf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mqlf_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mqlf_pkg::ST_INIT: begin
        if (sts_i.init_last) begin
          state_d = mqlf_pkg::ST_IDLE;
        end
      end
      mqlf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.day_bad) begin
            state_d = mqlf_pkg::ST_SINGLE;
          end else if (sts_i.kind == mqlf_pkg::KIND_ENQ) begin
            state_d = sts_i.pool_full ? mqlf_pkg::ST_SINGLE : mqlf_pkg::ST_ENQ_FIN;
          end else begin
            state_d = sts_i.queue_empty ? mqlf_pkg::ST_SINGLE : mqlf_pkg::ST_DRAIN;
          end
        end
      end
      mqlf_pkg::ST_ENQ_FIN: begin
        state_d = mqlf_pkg::ST_IDLE;
      end
      mqlf_pkg::ST_SINGLE: begin
        if (sts_i.slot_free) begin
          state_d = mqlf_pkg::ST_IDLE;
        end
      end
      mqlf_pkg::ST_DRAIN: begin
        if (sts_i.slot_free && sts_i.walk_final) begin
          state_d = mqlf_pkg::ST_IDLE;
        end
      end
      default: state_d = mqlf_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.code = mqlf_pkg::RES_ENTRY;
    in_stall_o = 1'b1;
    case (state_q)
      mqlf_pkg::ST_INIT: begin
        cmd_o.init_wr = 1'b1;
      end
      mqlf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.day_bad) begin
            cmd_o.code = mqlf_pkg::RES_BADDAY;
          end else if (sts_i.kind == mqlf_pkg::KIND_ENQ) begin
            if (sts_i.pool_full) begin
              cmd_o.code = mqlf_pkg::RES_FULL;
            end else begin
              cmd_o.enq_start = 1'b1;
            end
          end else begin
            if (sts_i.queue_empty) begin
              cmd_o.code = mqlf_pkg::RES_EMPTY;
            end else begin
              cmd_o.drain_start = 1'b1;
            end
          end
        end
      end
      mqlf_pkg::ST_ENQ_FIN: begin
        cmd_o.enq_fin = 1'b1;
      end
      mqlf_pkg::ST_SINGLE: begin
        cmd_o.single_load = sts_i.slot_free;
      end
      mqlf_pkg::ST_DRAIN: begin
        cmd_o.drain_emit = sts_i.slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mqlf_datapath.sv =====
// Datapath: queue pointers, free list, link and payload memories, result register.
`timescale 1ns / 1ps
`default_nettype none

module mqlf_datapath #(
  parameter int NUM_QUEUES = 7,
  parameter int POOL_DEPTH = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mqlf_pkg::mqlf_cmd_t    cmd_i,
  output mqlf_pkg::mqlf_status_t      sts_o,
  input  wire logic                   kind_i,
  input  wire logic [2:0]             day_i,
  input  wire logic [15:0]            film_id_i,
  input  wire logic [15:0]            client_id_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [1:0]                  status_o,
  output logic [15:0]                 out_film_o,
  output logic [15:0]                 out_client_o,
  output logic                        last_o
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int QW = $clog2(NUM_QUEUES);

  logic [QW-1:0]         qidx;
  logic                  day_bad;
  logic [NUM_QUEUES-1:0] nonempty_q;
  logic [AW-1:0]         head_q [NUM_QUEUES];
  logic [AW-1:0]         tail_q [NUM_QUEUES];
  logic [AW-1:0]         free_head_q;
  logic [CW-1:0]         free_count_q;
  logic [AW-1:0]         init_cnt_q;
  logic [AW-1:0]         init_next;
  logic                  init_last;
  logic [AW-1:0]         cur_q;
  logic [AW-1:0]         dtail_q;
  logic [AW-1:0]         walk_cnt_q;
  logic                  walk_final;
  mqlf_pkg::mqlf_res_e   code_q;
  logic                  out_valid_q;
  logic                  slot_free;

  logic                  link_we;
  logic [AW-1:0]         link_waddr;
  logic [AW-1:0]         link_wdata;
  logic                  link_re;
  logic [AW-1:0]         link_raddr;
  logic [AW-1:0]         link_rdata;
  logic                  pay_re;
  logic [31:0]           pay_rdata;
  logic                  walk_next;

  assign qidx       = QW'(day_i);
  assign day_bad    = (32'(day_i) >= NUM_QUEUES);
  assign init_last  = (init_cnt_q == AW'(POOL_DEPTH - 1));
  assign init_next  = init_last ? '0 : init_cnt_q + AW'(1);
  assign walk_final = (cur_q == dtail_q) || (walk_cnt_q == AW'(POOL_DEPTH - 1));
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign walk_next  = cmd_i.drain_emit && !walk_final;

  assign sts_o.kind        = kind_i;
  assign sts_o.day_bad     = day_bad;
  assign sts_o.pool_full   = (free_count_q == '0);
  assign sts_o.queue_empty = !nonempty_q[qidx];
  assign sts_o.slot_free   = slot_free;
  assign sts_o.init_last   = init_last;
  assign sts_o.walk_final  = walk_final;

  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur_q;
    link_wdata = free_head_q;
    if (cmd_i.init_wr) begin
      link_we    = 1'b1;
      link_waddr = init_cnt_q;
      link_wdata = init_next;
    end else if (cmd_i.enq_start && nonempty_q[qidx]) begin
      link_we    = 1'b1;
      link_waddr = tail_q[qidx];
    end else if (cmd_i.drain_emit) begin
      link_we    = 1'b1;
    end
  end

  assign link_re    = cmd_i.enq_start || cmd_i.drain_start || walk_next;
  assign link_raddr = cmd_i.enq_start   ? free_head_q  :
                      cmd_i.drain_start ? head_q[qidx] : link_rdata;
  assign pay_re     = cmd_i.drain_start || walk_next;

  mqlf_ram #(
    .WIDTH (AW),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  mqlf_ram #(
    .WIDTH (32),
    .DEPTH (POOL_DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.enq_start),
    .waddr_i (free_head_q),
    .wdata_i ({film_id_i, client_id_i}),
    .re_i    (pay_re),
    .raddr_i (cmd_i.drain_start ? head_q[qidx] : link_rdata),
    .rdata_o (pay_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q   <= '0;
      nonempty_q   <= '0;
      free_head_q  <= '0;
      free_count_q <= CW'(POOL_DEPTH);
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.init_wr) begin
        init_cnt_q <= init_next;
      end
      if (cmd_i.enq_start) begin
        nonempty_q[qidx] <= 1'b1;
        free_count_q     <= free_count_q - CW'(1);
      end
      if (cmd_i.drain_start) begin
        nonempty_q[qidx] <= 1'b0;
      end
      if (cmd_i.enq_fin) begin
        free_head_q <= link_rdata;
      end
      if (cmd_i.drain_emit) begin
        free_head_q <= cur_q;
        if (free_count_q < CW'(POOL_DEPTH)) begin
          free_count_q <= free_count_q + CW'(1);
        end
      end
      if (cmd_i.drain_emit || cmd_i.single_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_start) begin
      tail_q[qidx] <= free_head_q;
      if (!nonempty_q[qidx]) begin
        head_q[qidx] <= free_head_q;
      end
    end
    if (cmd_i.accept) begin
      code_q <= cmd_i.code;
    end
    if (cmd_i.drain_start) begin
      cur_q      <= head_q[qidx];
      dtail_q    <= tail_q[qidx];
      walk_cnt_q <= '0;
    end else if (cmd_i.drain_emit) begin
      cur_q      <= link_rdata;
      walk_cnt_q <= walk_cnt_q + AW'(1);
    end
    if (cmd_i.drain_emit) begin
      status_o     <= mqlf_pkg::RES_ENTRY;
      out_film_o   <= pay_rdata[31:16];
      out_client_o <= pay_rdata[15:0];
      last_o       <= walk_final;
    end else if (cmd_i.single_load) begin
      status_o     <= code_q;
      out_film_o   <= '0;
      out_client_o <= '0;
      last_o       <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for multi_queue_linked_fifo: random and directed reservations with a predictor.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_DAYS   = 7;
  localparam int POOL       = 64;
  localparam int SETTLE     = 80;
  localparam int HOLD_LEN   = 300;
  localparam int STALL_LIMIT = 4000;
  localparam logic [2:0] BAD_DAY = 3'd7;

  typedef struct packed {
    logic        kind;
    logic [2:0]  day;
    logic [15:0] film;
    logic [15:0] client;
  } booking_t;

  typedef struct packed {
    mqlf_pkg::mqlf_res_e status;
    logic [15:0]         film;
    logic [15:0]         client;
    logic                last;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [2:0]  day = 3'd0;
  logic [15:0] film = 16'd0;
  logic [15:0] client = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] out_film;
  logic [15:0] out_client;
  logic        last;

  booking_t booking_q[$];
  reply_t   reply_q[$];
  int       mismatches = 0;
  int       quiet_cycles = 0;
  logic     steady = 1'b0;
  logic     hold_req = 1'b0;
  logic     hold_taken = 1'b0;
  int       hold_left = 0;

  logic        day_busy[NUM_DAYS];
  logic [5:0]  day_head[NUM_DAYS];
  logic [5:0]  day_tail[NUM_DAYS];
  logic [5:0]  next_slot[POOL];
  logic [31:0] slot_data[POOL];
  logic [5:0]  free_head;
  logic [6:0]  free_count;

  multi_queue_linked_fifo uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (kind),
    .day_i        (day),
    .film_id_i    (film),
    .client_id_i  (client),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .out_film_o   (out_film),
    .out_client_o (out_client),
    .last_o       (last)
  );

  always #5 clk = ~clk;

  function automatic reply_t single_reply(input mqlf_pkg::mqlf_res_e code);
    reply_t r;
    r.status = code;
    r.film   = 16'd0;
    r.client = 16'd0;
    r.last   = 1'b1;
    return r;
  endfunction

  task automatic book_or_drain(input booking_t b);
    reply_t     r;
    logic [5:0] e;
    logic [5:0] nxt;
    logic       fin;
    logic       done;
    int         n;
    if (b.day >= NUM_DAYS) begin
      reply_q.push_back(single_reply(mqlf_pkg::RES_BADDAY));
    end else if (b.kind == mqlf_pkg::KIND_ENQ) begin
      if (free_count == 0) begin
        reply_q.push_back(single_reply(mqlf_pkg::RES_FULL));
      end else begin
        e = free_head;
        free_head = next_slot[e];
        free_count = free_count - 1;
        slot_data[e] = {b.film, b.client};
        if (day_busy[b.day]) begin
          next_slot[day_tail[b.day]] = e;
        end else begin
          day_head[b.day] = e;
          day_busy[b.day] = 1'b1;
        end
        day_tail[b.day] = e;
      end
    end else if (!day_busy[b.day]) begin
      reply_q.push_back(single_reply(mqlf_pkg::RES_EMPTY));
    end else begin
      e = day_head[b.day];
      done = 1'b0;
      for (n = 0; n < POOL && !done; n++) begin
        nxt = next_slot[e];
        fin = (e == day_tail[b.day]) || (n == POOL - 1);
        r.status = mqlf_pkg::RES_ENTRY;
        r.film   = slot_data[e][31:16];
        r.client = slot_data[e][15:0];
        r.last   = fin;
        reply_q.push_back(r);
        next_slot[e] = free_head;
        free_head = e;
        if (free_count < POOL) free_count = free_count + 1;
        done = fin;
        e = nxt;
      end
      day_busy[b.day] = 1'b0;
    end
  endtask

  function automatic booking_t mk(input logic k, input logic [2:0] d,
                                  input logic [15:0] f, input logic [15:0] c);
    booking_t b;
    b.kind   = k;
    b.day    = d;
    b.film   = f;
    b.client = c;
    return b;
  endfunction

  function automatic booking_t random_booking();
    int roll;
    roll = $urandom_range(99);
    if (roll < 6)
      return mk(1'($urandom_range(1)), BAD_DAY, 16'($urandom), 16'($urandom));
    else if (roll < 68)
      return mk(mqlf_pkg::KIND_ENQ, 3'($urandom_range(NUM_DAYS - 1)), 16'($urandom),
                16'($urandom));
    else
      return mk(mqlf_pkg::KIND_DRAIN, 3'($urandom_range(NUM_DAYS - 1)), 16'($urandom),
                16'($urandom));
  endfunction

  task automatic wait_drained();
    while (booking_q.size() != 0 || in_valid || reply_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      kind     <= 1'b0;
      day      <= 3'd0;
      film     <= 16'd0;
      client   <= 16'd0;
    end else begin
      if (in_valid && !in_stall) book_or_drain(mk(kind, day, film, client));
      if (!(in_valid && in_stall)) begin
        if (booking_q.size() != 0 && (steady || $urandom_range(99) >= 38)) begin
          {kind, day, film, client} <= booking_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_LEN;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 38);
    end
  end

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {status, out_film, out_client, last};
      if (reply_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: status %0d film %h client %h last %0d",
                   got.status, got.film, got.client, got.last);
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        if (got.status != want.status || got.film != want.film ||
            got.client != want.client || got.last != want.last) begin
          if (mismatches < 10)
            $display("mismatch: status %0d/%0d film %h/%h client %h/%h last %0d/%0d",
                     want.status, got.status, want.film, got.film,
                     want.client, got.client, want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int i;
    int fill_day;
    for (i = 0; i < NUM_DAYS; i++) begin
      day_busy[i] = 1'b0;
      day_head[i] = 6'd0;
      day_tail[i] = 6'd0;
    end
    for (i = 0; i < POOL; i++) begin
      next_slot[i] = 6'((i + 1) % POOL);
      slot_data[i] = 32'd0;
    end
    free_head  = 6'd0;
    free_count = 7'(POOL);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    booking_q.push_back(mk(mqlf_pkg::KIND_DRAIN, 3'd0, 16'h0000, 16'h0000));
    booking_q.push_back(mk(mqlf_pkg::KIND_ENQ, BAD_DAY, 16'hFFFF, 16'hFFFF));
    booking_q.push_back(mk(mqlf_pkg::KIND_DRAIN, BAD_DAY, 16'h1234, 16'h4321));
    booking_q.push_back(mk(mqlf_pkg::KIND_ENQ, 3'd0, 16'h0000, 16'hFFFF));
    booking_q.push_back(mk(mqlf_pkg::KIND_ENQ, 3'd0, 16'hFFFF, 16'h0000));
    booking_q.push_back(mk(mqlf_pkg::KIND_ENQ, 3'd6, 16'hA5A5, 16'h5A5A));
    booking_q.push_back(mk(mqlf_pkg::KIND_ENQ, 3'd3, 16'h5A5A, 16'hA5A5));
    booking_q.push_back(mk(mqlf_pkg::KIND_DRAIN, 3'd0, 16'hFFFF, 16'hFFFF));
    booking_q.push_back(mk(mqlf_pkg::KIND_DRAIN, 3'd6, 16'h0000, 16'h0000));
    booking_q.push_back(mk(mqlf_pkg::KIND_DRAIN, 3'd6, 16'h0000, 16'h0000));
    booking_q.push_back(mk(mqlf_pkg::KIND_DRAIN, 3'd3, 16'h0000, 16'h0000));
    for (i = 0; i < 3; i++)
      booking_q.push_back(mk(mqlf_pkg::KIND_ENQ, 3'd1, 16'($urandom), 16'($urandom)));
    booking_q.push_back(mk(mqlf_pkg::KIND_ENQ, 3'd5, 16'hFFFF, 16'hFFFF));
    booking_q.push_back(mk(mqlf_pkg::KIND_ENQ, 3'd4, 16'h0001, 16'h8000));
    booking_q.push_back(mk(mqlf_pkg::KIND_DRAIN, 3'd1, 16'h0000, 16'h0000));
    booking_q.push_back(mk(mqlf_pkg::KIND_DRAIN, 3'd5, 16'h0000, 16'h0000));
    booking_q.push_back(mk(mqlf_pkg::KIND_DRAIN, 3'd4, 16'h0000, 16'h0000));
    wait_drained();

    steady = 1'b1;
    fill_day = $urandom_range(NUM_DAYS - 1);
    for (i = 0; i < POOL + 2; i++)
      booking_q.push_back(mk(mqlf_pkg::KIND_ENQ, 3'(fill_day), 16'($urandom), 16'($urandom)));
    booking_q.push_back(mk(mqlf_pkg::KIND_DRAIN, 3'(fill_day), 16'($urandom),
                           16'($urandom)));
    wait_drained();
    steady = 1'b0;

    hold_req = 1'b1;
    for (i = 0; i < 6; i++)
      booking_q.push_back(mk(mqlf_pkg::KIND_ENQ, 3'd2, 16'($urandom), 16'($urandom)));
    booking_q.push_back(mk(mqlf_pkg::KIND_DRAIN, 3'd2, 16'($urandom), 16'($urandom)));
    for (i = 0; i < 20; i++)
      booking_q.push_back(random_booking());
    wait_drained();

    for (i = 0; i < 40; i++)
      booking_q.push_back(random_booking());
    wait_drained();

    if (reply_q.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
